/* rtl/etf_pkg.sv */
// ----------------------------------------------------------------------------
// etf_pkg
// Shared types and fixed constants of the escape-time fractal iterator:
// register indexes, formula codes, reset values and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package etf_pkg;

   localparam int COUNT_W     = 16;
   localparam int STYLE_W     = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_STYLE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT = 1'd1;

   localparam logic [STYLE_W-1:0] STYLE_MANDEL = 2'd0;
   localparam logic [STYLE_W-1:0] STYLE_CUBIC  = 2'd1;
   localparam logic [STYLE_W-1:0] STYLE_REAL   = 2'd2;
   localparam logic [STYLE_W-1:0] STYLE_SKEW   = 2'd3;

   localparam logic [STYLE_W-1:0] STYLE_RESET = STYLE_MANDEL;
   localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd1000;

   typedef struct packed {
      logic load;   // capture c, clear z and count
      logic mul;    // register x*x, y*y, x*y and the range/limit flags
      logic mul2;   // register the cubic-mix second products
      logic step;   // commit the new z, bump the count
      logic emit;   // load the result register
   } cmd_type;

   typedef struct packed {
      logic finish; // escaped or limit reached
      logic cubic;  // formula needs the second multiply pass
   } status_type;

endpackage

/* rtl/etf_req_if.sv */
// ----------------------------------------------------------------------------
// etf_req_if
// Point channel: valid/ready handshake carrying one complex point c.
// ----------------------------------------------------------------------------
interface etf_req_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] c_real;
   logic signed [COORD_WIDTH-1:0] c_imag;

   modport source (output valid, output c_real, output c_imag, input ready);
   modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

/* rtl/etf_rsp_if.sv */
// ----------------------------------------------------------------------------
// etf_rsp_if
// Result channel: valid/ready handshake carrying count, inside flag and last z.
// ----------------------------------------------------------------------------
interface etf_rsp_if #(
   parameter int COORD_WIDTH = 32
);
   import etf_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [COUNT_W-1:0]            iteration_count;
   logic                          inside_res;
   logic signed [COORD_WIDTH-1:0] final_real;
   logic signed [COORD_WIDTH-1:0] final_imag;

   modport source (output valid, output iteration_count, output inside_res,
                   output final_real, output final_imag, input ready);
   modport sink   (input valid, input iteration_count, input inside_res,
                   input final_real, input final_imag, output ready);
endinterface

/* rtl/etf_datapath.sv */
// ----------------------------------------------------------------------------
// etf_datapath
// Configuration registers, z state, shared multipliers, escape test,
// update rules and the result register.
// ----------------------------------------------------------------------------
module etf_datapath import etf_pkg::*; #(
   parameter int FRAC_BITS   = 26,
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  logic signed [COORD_WIDTH-1:0] req_c_real,
   input  logic signed [COORD_WIDTH-1:0] req_c_imag,
   input  cmd_type                       cmd,
   output status_type                    status,
   output logic [COUNT_W-1:0]            rsp_iteration_count,
   output logic                          rsp_inside_res,
   output logic signed [COORD_WIDTH-1:0] rsp_final_real,
   output logic signed [COORD_WIDTH-1:0] rsp_final_imag
);

   // z width: |c| plus the largest update term, with sign
   localparam int ZW = ((COORD_WIDTH > FRAC_BITS + 5) ? COORD_WIDTH : FRAC_BITS + 5) + 1;
   localparam int MW = FRAC_BITS + 3;
   localparam int PW = 2 * MW;

   localparam logic signed [ZW-1:0] TWO =
      {{(ZW-FRAC_BITS-2){1'b0}}, 2'b10, {FRAC_BITS{1'b0}}};
   localparam logic signed [ZW-1:0] NEG_TWO = -TWO;
   localparam logic [PW:0] ESC_LIM =
      {{(PW-2*FRAC_BITS-2){1'b0}}, 1'b1, {(2*FRAC_BITS+2){1'b0}}};
   localparam logic signed [ZW-1:0] SAT_MAX =
      {{(ZW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [ZW-1:0] SAT_MIN = ~SAT_MAX;

   logic [STYLE_W-1:0]            style_ff;
   logic [COUNT_W-1:0]            limit_ff;
   logic signed [COORD_WIDTH-1:0] cr_ff, ci_ff;
   logic signed [ZW-1:0]          x_ff, y_ff, x_in, y_in;
   logic [COUNT_W-1:0]            count_ff, count_in;
   logic signed [PW-1:0]          xx_ff, yy_ff, xy_ff, p1_ff, p2_ff;
   logic                          in_range_ff, in_range_in;
   logic                          limit_hit_ff;

   logic signed [MW-1:0] xo, yo, x2o, y2o, ma_a, ma_b, mb_a, mb_b;
   logic signed [PW-1:0] xx_sh, yy_sh, prod_a, prod_b, prod_c;
   logic signed [PW-1:0] re_full, im_full, re_sh, im_sh;
   logic signed [ZW-1:0] cr_ext, ci_ext;
   logic [PW:0]          mag_sum;
   logic signed [COORD_WIDTH-1:0] sat_re, sat_im;

   // operands: in range |z| < 2 fits in MW bits
   assign xo    = x_ff[MW-1:0];
   assign yo    = y_ff[MW-1:0];
   assign xx_sh = xx_ff >>> FRAC_BITS;
   assign yy_sh = yy_ff >>> FRAC_BITS;
   assign x2o   = xx_sh[MW-1:0];
   assign y2o   = yy_sh[MW-1:0];

   assign ma_a = cmd.mul2 ? x2o : xo;
   assign ma_b = cmd.mul2 ? yo  : xo;
   assign mb_a = cmd.mul2 ? y2o : yo;
   assign mb_b = cmd.mul2 ? xo  : yo;

   assign prod_a = ma_a * ma_b;
   assign prod_b = mb_a * mb_b;
   assign prod_c = xo * yo;

   assign in_range_in = (x_ff > NEG_TWO) && (x_ff < TWO) &&
                        (y_ff > NEG_TWO) && (y_ff < TWO);

   always_comb begin
      case (style_ff)
         STYLE_MANDEL: re_full = xx_ff - yy_ff;
         STYLE_CUBIC:  re_full = p1_ff - p2_ff;
         STYLE_REAL:   re_full = xx_ff;
         STYLE_SKEW:   re_full = xy_ff - yy_ff;
         default:      re_full = xy_ff - yy_ff;
      endcase
   end

   assign im_full = xy_ff <<< 1;
   assign re_sh   = re_full >>> FRAC_BITS;
   assign im_sh   = im_full >>> FRAC_BITS;
   assign cr_ext  = {{(ZW-COORD_WIDTH){cr_ff[COORD_WIDTH-1]}}, cr_ff};
   assign ci_ext  = {{(ZW-COORD_WIDTH){ci_ff[COORD_WIDTH-1]}}, ci_ff};

   assign x_in     = re_sh[ZW-1:0] + cr_ext;
   assign y_in     = (style_ff == STYLE_REAL) ? '0 : im_sh[ZW-1:0] + ci_ext;
   assign count_in = count_ff + COUNT_W'(1);

   assign mag_sum = {1'b0, xx_ff} + {1'b0, yy_ff};

   assign status.finish = !in_range_ff || (mag_sum >= ESC_LIM) || limit_hit_ff;
   assign status.cubic  = (style_ff == STYLE_CUBIC);

   assign sat_re = (x_ff > SAT_MAX) ? SAT_MAX[COORD_WIDTH-1:0] :
                   (x_ff < SAT_MIN) ? SAT_MIN[COORD_WIDTH-1:0] : x_ff[COORD_WIDTH-1:0];
   assign sat_im = (y_ff > SAT_MAX) ? SAT_MAX[COORD_WIDTH-1:0] :
                   (y_ff < SAT_MIN) ? SAT_MIN[COORD_WIDTH-1:0] : y_ff[COORD_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         style_ff <= STYLE_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STYLE: style_ff <= csr_wdata[STYLE_W-1:0];
            CSR_LIMIT: limit_ff <= csr_wdata[COUNT_W-1:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cr_ff    <= req_c_real;
         ci_ff    <= req_c_imag;
         x_ff     <= '0;
         y_ff     <= '0;
         count_ff <= '0;
      end else if (cmd.step) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         count_ff <= count_in;
      end
      if (cmd.mul) begin
         xx_ff        <= prod_a;
         yy_ff        <= prod_b;
         xy_ff        <= prod_c;
         in_range_ff  <= in_range_in;
         limit_hit_ff <= (count_ff >= limit_ff);
      end
      if (cmd.mul2) begin
         p1_ff <= prod_a;
         p2_ff <= prod_b;
      end
      if (cmd.emit) begin
         rsp_iteration_count <= count_ff;
         rsp_inside_res      <= limit_hit_ff;
         rsp_final_real      <= sat_re;
         rsp_final_imag      <= sat_im;
      end
   end

   a_step_only_live: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> in_range_ff && !limit_hit_ff && (count_ff < limit_ff))
      else $error("step taken on an escaped or exhausted point");

   a_step_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("iteration count did not advance by one");

   a_inside_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_inside_res == (rsp_iteration_count >= limit_ff))
      else $error("inside flag disagrees with count and limit");

endmodule

/* rtl/etf_ctrl.sv */
// ----------------------------------------------------------------------------
// etf_ctrl
// Sequencer for one point: load, multiply pass(es), escape/update, result
// hand-off. Owns the handshake of both channels.
// ----------------------------------------------------------------------------
module etf_ctrl import etf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_MUL2,
      ST_UPD
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: cmd.load = req_valid;
         ST_MUL:  cmd.mul  = 1'b1;
         ST_MUL2: cmd.mul2 = 1'b1;
         ST_UPD: begin
            if (status.finish) begin
               cmd.emit = out_free;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: if (req_valid) state_ff <= ST_MUL;
            ST_MUL:  state_ff <= status.cubic ? ST_MUL2 : ST_UPD;
            ST_MUL2: state_ff <= ST_UPD;
            ST_UPD: begin
               if (!status.finish) begin
                  state_ff <= ST_MUL;
               end else if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_MUL)
      else $error("accepted transaction did not start a multiply pass");

   a_emit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> !cmd.emit || $past(cmd.emit) == 1'b0)
      else $error("result register overwritten while held");

endmodule

/* rtl/escape_time_fractal_iterator.sv */
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator
// Fixed-point escape-time iterator for one complex point per transaction.
// ----------------------------------------------------------------------------
// One point is worked at a time. Each iteration is a registered multiply
// pass for x*x, y*y and x*y, then the escape test and z update; the
// cubic-mix formula adds a second multiply pass. The time to a result grows
// with the final count, so the iteration limit sets the worst case; the
// result also waits while the previous result still holds the output
// register. A new point is accepted while the previous result still waits
// on the output register.
// z is held wide internally; only the reported z saturates.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator import etf_pkg::*; #(
   parameter int FRAC_BITS   = 26,
   parameter int COORD_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   etf_req_if.sink                req_ch,
   etf_rsp_if.source              rsp_ch
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

   etf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   etf_datapath #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_c_real          (req_ch.c_real),
      .req_c_imag          (req_ch.c_imag),
      .cmd                 (cmd),
      .status              (status),
      .rsp_iteration_count (rsp_ch.iteration_count),
      .rsp_inside_res      (rsp_ch.inside_res),
      .rsp_final_real      (rsp_ch.final_real),
      .rsp_final_imag      (rsp_ch.final_imag)
   );

endmodule

/* dv/tb_escape_time_fractal_iterator.sv */
// ----------------------------------------------------------------------------
// tb_escape_time_fractal_iterator
// Self-checking bench for the escape-time iterator. Points go in over the
// request channel with random gaps and results are taken with random
// stalls. A scoreboard replays each accepted point through its own
// fixed-point iteration under the current style and limit, then compares
// count, inside flag and final z. Directed points cover the number range
// extremes, the escape radius, all four formulas, a zero limit, escape on the
// last allowed step and the largest limit. Random phases follow, each with
// fresh register settings.
// ----------------------------------------------------------------------------
module tb_escape_time_fractal_iterator;
   import etf_pkg::*;

   localparam int FRAC          = 26;
   localparam int COORD         = 32;
   localparam int STALL_LIMIT   = 1_000_000;
   localparam int RANDOM_POINTS = 550;

   localparam logic signed [COORD-1:0] Q_ONE = 32'sh0400_0000;
   localparam logic signed [COORD-1:0] Q_TWO = 32'sh0800_0000;
   localparam logic signed [COORD-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD-1:0] Q_MIN = 32'sh8000_0000;
   // sqrt(2) just under and just over, in Q6.26
   localparam logic signed [COORD-1:0] Q_RT2_LO = 32'sh05A8_2799;
   localparam logic signed [COORD-1:0] Q_RT2_HI = 32'sh05A8_279A;

   localparam longint ESC_BOUND   = 64'sd2 <<< FRAC;
   localparam longint ESC_RADIUS2 = 64'sd4 <<< (2 * FRAC);

   typedef struct packed {
      logic [COUNT_W-1:0]      count;
      logic                    at_limit;
      logic signed [COORD-1:0] re;
      logic signed [COORD-1:0] im;
   } escape_type;

   class escape_scoreboard;
      logic [STYLE_W-1:0] style;
      logic [COUNT_W-1:0] limit;
      escape_type         pending[$];
      int                 mismatches;

      function new();
         style      = STYLE_RESET;
         limit      = LIMIT_RESET;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_STYLE) begin
            style = data[STYLE_W-1:0];
         end else if (idx == CSR_LIMIT) begin
            limit = data[COUNT_W-1:0];
         end
      endfunction

      function logic signed [COORD-1:0] clamp(longint v);
         if (v > 64'sd2147483647) begin
            return Q_MAX;
         end
         if (v < -64'sd2147483648) begin
            return Q_MIN;
         end
         return v[COORD-1:0];
      endfunction

      // z is kept wide; every rescale is an arithmetic (floor) shift
      function escape_type escape_point(longint cr, longint ci);
         longint      x, y, xx, yy, xy, nr, ni;
         int unsigned n;
         escape_type  e;
         x = 0;
         y = 0;
         n = 0;
         forever begin
            if (n >= limit) break;
            if (x >= ESC_BOUND || x <= -ESC_BOUND || y >= ESC_BOUND || y <= -ESC_BOUND) break;
            if (x * x + y * y >= ESC_RADIUS2) break;
            xx = x * x;
            yy = y * y;
            xy = x * y;
            case (style)
               STYLE_MANDEL: begin
                  nr = ((xx - yy) >>> FRAC) + cr;
                  ni = ((2 * xy) >>> FRAC) + ci;
               end
               STYLE_CUBIC: begin
                  nr = ((((xx >>> FRAC) * y) - ((yy >>> FRAC) * x)) >>> FRAC) + cr;
                  ni = ((2 * xy) >>> FRAC) + ci;
               end
               STYLE_REAL: begin
                  nr = (xx >>> FRAC) + cr;
                  ni = 0;
               end
               default: begin
                  nr = ((xy - yy) >>> FRAC) + cr;
                  ni = ((2 * xy) >>> FRAC) + ci;
               end
            endcase
            x = nr;
            y = ni;
            n++;
         end
         e.count    = n[COUNT_W-1:0];
         e.at_limit = (n >= limit);
         e.re       = clamp(x);
         e.im       = clamp(y);
         return e;
      endfunction

      function void note_point(logic signed [COORD-1:0] cr, logic signed [COORD-1:0] ci);
         pending.push_back(escape_point(cr, ci));
      endfunction

      function void check_escape(escape_type got);
         escape_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transaction: count %0d inside %0b z (%0d, %0d)",
                        got.count, got.at_limit, got.re, got.im);
            return;
         end
         want = pending.pop_front();
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %0d/%0b (%0d, %0d), got %0d/%0b (%0d, %0d)",
                        want.count, want.at_limit, want.re, want.im,
                        got.count, got.at_limit, got.re, got.im);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   bit                     steady;
   int                     quiet_cycles = 0;

   escape_scoreboard ledger = new();

   etf_req_if #(.COORD_WIDTH(COORD)) req_ch ();
   etf_rsp_if #(.COORD_WIDTH(COORD)) rsp_ch ();

   escape_time_fractal_iterator #(
      .FRAC_BITS  (FRAC),
      .COORD_WIDTH(COORD)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      escape_type got;
      if (!reset) begin
         if (csr_we) ledger.write_reg(csr_index, csr_wdata);
         if (req_ch.valid && req_ch.ready) ledger.note_point(req_ch.c_real, req_ch.c_imag);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.count    = rsp_ch.iteration_count;
            got.at_limit = rsp_ch.inside_res;
            got.re       = rsp_ch.final_real;
            got.im       = rsp_ch.final_imag;
            ledger.check_escape(got);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // result sink with a random stall before each transaction
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         @(negedge clock);
      end
   end

   function automatic logic signed [COORD-1:0] draw_coord();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) return $urandom;
      if (pick < 8) return int'($urandom_range(0, 32'h1000_0000)) - int'(Q_TWO);
      return int'($urandom_range(0, 32'h0800_0000)) - 32'sh0600_0000;
   endfunction

   task automatic send_point(input logic signed [COORD-1:0] re,
                             input logic signed [COORD-1:0] im);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.c_real <= re;
      req_ch.c_imag <= im;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      @(negedge clock);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (ledger.pending.size() != 0) @(negedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] style_word,
                            input logic [CSR_DATA_W-1:0] limit_word);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_STYLE;
      csr_wdata <= style_word;
      @(negedge clock);
      csr_index <= CSR_LIMIT;
      csr_wdata <= limit_word;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int                    sent;
      int                    n;
      int unsigned           pick;
      logic [CSR_DATA_W-1:0] word;
      logic [CSR_DATA_W-1:0] lim;
      csr_we        = 1'b0;
      csr_index     = CSR_STYLE;
      csr_wdata     = '0;
      req_ch.valid  = 1'b0;
      req_ch.c_real = '0;
      req_ch.c_imag = '0;
      steady        = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: mandelbrot, limit 1000
      send_point('0, '0);
      send_point(Q_MAX, Q_MAX);
      send_point(Q_MIN, Q_MIN);
      send_point(Q_TWO, '0);
      send_point(-Q_TWO, '0);
      send_point(Q_ONE, Q_ONE);
      send_point(Q_RT2_LO, Q_RT2_LO);
      send_point(Q_RT2_HI, Q_RT2_HI);
      send_point(-Q_ONE, '0);
      send_point(Q_ONE >>> 2, '0);
      send_point(32'sh0000_0001, -32'sh0000_0001);

      configure({14'h3FFF, STYLE_CUBIC}, 16'd50);
      send_point('0, '0);
      send_point(-(Q_ONE >>> 1), Q_ONE >>> 1);
      configure({14'h0000, STYLE_REAL}, 16'd50);
      send_point(-(Q_ONE + (Q_ONE >>> 1)), Q_ONE);
      send_point(Q_ONE >>> 3, Q_MAX);
      configure({14'h2AAA, STYLE_SKEW}, 16'd50);
      send_point(Q_ONE >>> 1, -(Q_ONE >>> 1));
      send_point(-Q_ONE, Q_ONE >>> 2);

      // zero limit: no iteration at all
      configure({14'h1555, STYLE_MANDEL}, 16'd0);
      send_point(Q_ONE, Q_ONE);
      send_point(Q_MIN, Q_MAX);

      // escape lands on the last allowed step
      configure({14'h0000, STYLE_MANDEL}, 16'd2);
      send_point(Q_ONE, '0);

      configure({14'h3FFF, STYLE_CUBIC}, 16'hFFFF);
      send_point('0, '0);
      send_point(Q_MAX, '0);

      sent = 0;
      while (sent < RANDOM_POINTS) begin
         word = CSR_DATA_W'($urandom);
         word[STYLE_W-1:0] = STYLE_W'($urandom_range(0, 3));
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            lim = CSR_DATA_W'($urandom_range(1, 64));
         end else if (pick < 9) begin
            lim = CSR_DATA_W'($urandom_range(65, 400));
         end else begin
            lim = CSR_DATA_W'($urandom_range(0, 2));
         end
         configure(word, lim);
         steady = ($urandom_range(0, 4) == 0);
         n = $urandom_range(15, 40);
         repeat (n) send_point(draw_coord(), draw_coord());
         sent += n;
      end

      settle();
      repeat (16) @(negedge clock);
      if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/etf_pkg.sv
rtl/etf_req_if.sv
rtl/etf_rsp_if.sv
rtl/etf_datapath.sv
rtl/etf_ctrl.sv
rtl/escape_time_fractal_iterator.sv
dv/tb_escape_time_fractal_iterator.sv
